>>> hdl/hexc_pkg.sv
// ============================================================================
// Harmonic exciter package
// Shared constants, microcode types and the microcode program of the
// harmonic exciter core.
// ============================================================================
package hexc_pkg;

  localparam int CHANNELS           = 8;
  localparam int COEF_FRACTION_BITS = 24;

  localparam int NCOEF     = 18;
  localparam int SLOTS     = 16;
  localparam int MEM_DEPTH = CHANNELS * SLOTS;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int PC_W      = 6;

  localparam logic [47:0] DEAD_ZONE =
    48'((64'd1 << COEF_FRACTION_BITS) / 64'd100000000);
  localparam logic [47:0] ONE_Q = 48'(64'd1 << COEF_FRACTION_BITS);
  localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

  localparam logic [2:0] CFG_LEVEL_IN  = 3'd0;
  localparam logic [2:0] CFG_LEVEL_OUT = 3'd1;
  localparam logic [2:0] CFG_AMOUNT    = 3'd2;
  localparam logic [2:0] CFG_LISTEN    = 3'd3;
  localparam logic [2:0] CFG_LOWPASS   = 3'd4;

  localparam logic [4:0] C_A1N     = 5'd0;
  localparam logic [4:0] C_A2N     = 5'd1;
  localparam logic [4:0] C_B0      = 5'd2;
  localparam logic [4:0] C_B1      = 5'd3;
  localparam logic [4:0] C_B2      = 5'd4;
  localparam logic [4:0] C_LP_BASE = 5'd5;
  localparam logic [4:0] C_AP      = 5'd10;
  localparam logic [4:0] C_KPA     = 5'd11;
  localparam logic [4:0] C_KPB     = 5'd12;
  localparam logic [4:0] C_AN      = 5'd13;
  localparam logic [4:0] C_KNA     = 5'd14;
  localparam logic [4:0] C_KNB     = 5'd15;
  localparam logic [4:0] C_PWRQ    = 5'd16;
  localparam logic [4:0] C_SRCT    = 5'd17;

  localparam logic [3:0] SLOT_DC0 = 4'd12;
  localparam logic [3:0] SLOT_DC1 = 4'd13;

  localparam logic [PC_W-1:0] PC_BODY  = 6'd1;
  localparam logic [PC_W-1:0] PC_NEG   = 6'd23;
  localparam logic [PC_W-1:0] PC_DC    = 6'd30;
  localparam logic [PC_W-1:0] PC_FINAL = 6'd39;
  localparam logic [PC_W-1:0] PC_OUTSC = 6'd43;

  typedef enum logic [2:0] {
    OP_NOP, OP_ADD, OP_DEAD, OP_LOAD, OP_STORE, OP_MUL, OP_SQRT, OP_END
  } op_t;

  typedef enum logic [3:0] {
    S_ZERO, S_X, S_BO, S_T1, S_T2, S_MED, S_Y, S_W0, S_W1,
    S_COEF, S_SAMPLE, S_LVIN, S_LVOUT, S_AMOUNT, S_ONE
  } src_t;

  typedef enum logic [3:0] {
    D_NONE, D_X, D_BO, D_T1, D_T2, D_MED, D_Y, D_W0, D_W1
  } dst_t;

  typedef enum logic [2:0] {SH_F, SH_IN, SH_OUT, SH_16, SH_23} sh_t;

  typedef enum logic [1:0] {M_BQ0, M_BQ1, M_DC0, M_DC1} mem_t;

  typedef enum logic [2:0] {
    CND_NONE, CND_ALWAYS, CND_XNEG, CND_LOOP, CND_WET_DONE, CND_LISTEN
  } cond_t;

  typedef struct packed {
    op_t             op;
    src_t            src_a;
    src_t            src_b;
    logic            neg_b;
    dst_t            dst;
    sh_t             sh;
    logic            coef_rel;
    logic [4:0]      coef_idx;
    mem_t            mem;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            bq_inc;
  } ctl_t;

  function automatic ctl_t f_op(op_t op, dst_t d, src_t a, src_t b, logic nb, sh_t sh);
    ctl_t c;
    c.op       = op;
    c.src_a    = a;
    c.src_b    = b;
    c.neg_b    = nb;
    c.dst      = d;
    c.sh       = sh;
    c.coef_rel = 1'b0;
    c.coef_idx = 5'd0;
    c.mem      = M_BQ0;
    c.cond     = CND_NONE;
    c.target   = '0;
    c.bq_inc   = 1'b0;
    return c;
  endfunction

  function automatic ctl_t f_mem(op_t op, dst_t d, src_t a, mem_t m);
    ctl_t c;
    c     = f_op(op, d, a, S_ZERO, 1'b0, SH_F);
    c.mem = m;
    return c;
  endfunction

  function automatic ctl_t f_coef(ctl_t ci, logic rel, logic [4:0] idx);
    ctl_t c;
    c          = ci;
    c.coef_rel = rel;
    c.coef_idx = idx;
    return c;
  endfunction

  function automatic ctl_t f_jmp(ctl_t ci, cond_t cnd, logic [PC_W-1:0] tgt, logic inc);
    ctl_t c;
    c        = ci;
    c.cond   = cnd;
    c.target = tgt;
    c.bq_inc = inc;
    return c;
  endfunction

  function automatic ctl_t ucode(logic [PC_W-1:0] pc);
    ctl_t c;
    c = f_op(OP_END, D_NONE, S_ZERO, S_ZERO, 1'b0, SH_F);
    case (pc)
      6'd0:  c = f_op(OP_MUL, D_X, S_SAMPLE, S_LVIN, 1'b0, SH_IN);
      6'd1:  c = f_coef(f_op(OP_MUL, D_T1, S_COEF, S_X, 1'b0, SH_F), 1'b1, C_B0);
      6'd2:  c = f_mem(OP_LOAD, D_W0, S_ZERO, M_BQ0);
      6'd3:  c = f_op(OP_ADD, D_BO, S_T1, S_W0, 1'b0, SH_F);
      6'd4:  c = f_coef(f_op(OP_MUL, D_T1, S_COEF, S_X, 1'b0, SH_F), 1'b1, C_B1);
      6'd5:  c = f_mem(OP_LOAD, D_W1, S_ZERO, M_BQ1);
      6'd6:  c = f_op(OP_ADD, D_T1, S_T1, S_W1, 1'b0, SH_F);
      6'd7:  c = f_coef(f_op(OP_MUL, D_T2, S_COEF, S_BO, 1'b0, SH_F), 1'b1, C_A1N);
      6'd8:  c = f_op(OP_ADD, D_T1, S_T1, S_T2, 1'b0, SH_F);
      6'd9:  c = f_mem(OP_STORE, D_NONE, S_T1, M_BQ0);
      6'd10: c = f_coef(f_op(OP_MUL, D_T1, S_COEF, S_X, 1'b0, SH_F), 1'b1, C_B2);
      6'd11: c = f_coef(f_op(OP_MUL, D_T2, S_COEF, S_BO, 1'b0, SH_F), 1'b1, C_A2N);
      6'd12: c = f_op(OP_ADD, D_T1, S_T1, S_T2, 1'b0, SH_F);
      6'd13: c = f_mem(OP_STORE, D_NONE, S_T1, M_BQ1);
      6'd14: c = f_jmp(f_op(OP_ADD, D_X, S_BO, S_ZERO, 1'b0, SH_F),
                       CND_LOOP, PC_BODY, 1'b1);
      6'd15: c = f_jmp(f_op(OP_NOP, D_NONE, S_ZERO, S_ZERO, 1'b0, SH_F),
                       CND_WET_DONE, PC_FINAL, 1'b0);
      6'd16: c = f_jmp(f_op(OP_NOP, D_NONE, S_ZERO, S_ZERO, 1'b0, SH_F),
                       CND_XNEG, PC_NEG, 1'b0);
      6'd17: c = f_coef(f_op(OP_ADD, D_T1, S_COEF, S_X, 1'b1, SH_F), 1'b0, C_KPA);
      6'd18: c = f_op(OP_MUL, D_T1, S_X, S_T1, 1'b0, SH_F);
      6'd19: c = f_coef(f_op(OP_ADD, D_T1, S_COEF, S_T1, 1'b0, SH_F), 1'b0, C_AP);
      6'd20: c = f_op(OP_SQRT, D_T1, S_T1, S_ZERO, 1'b0, SH_F);
      6'd21: c = f_coef(f_op(OP_ADD, D_T1, S_T1, S_COEF, 1'b0, SH_F), 1'b0, C_KPB);
      6'd22: c = f_jmp(f_coef(f_op(OP_MUL, D_MED, S_T1, S_COEF, 1'b0, SH_F), 1'b0, C_PWRQ),
                       CND_ALWAYS, PC_DC, 1'b0);
      6'd23: c = f_coef(f_op(OP_ADD, D_T1, S_COEF, S_X, 1'b0, SH_F), 1'b0, C_KNA);
      6'd24: c = f_op(OP_MUL, D_T1, S_X, S_T1, 1'b0, SH_F);
      6'd25: c = f_coef(f_op(OP_ADD, D_T1, S_COEF, S_T1, 1'b1, SH_F), 1'b0, C_AN);
      6'd26: c = f_op(OP_SQRT, D_T1, S_T1, S_ZERO, 1'b0, SH_F);
      6'd27: c = f_coef(f_op(OP_ADD, D_T1, S_T1, S_COEF, 1'b0, SH_F), 1'b0, C_KNB);
      6'd28: c = f_coef(f_op(OP_MUL, D_T1, S_T1, S_COEF, 1'b0, SH_F), 1'b0, C_PWRQ);
      6'd29: c = f_op(OP_ADD, D_MED, S_ZERO, S_T1, 1'b1, SH_F);
      6'd30: c = f_mem(OP_LOAD, D_W0, S_ZERO, M_DC0);
      6'd31: c = f_op(OP_ADD, D_T1, S_MED, S_W0, 1'b1, SH_F);
      6'd32: c = f_mem(OP_LOAD, D_W1, S_ZERO, M_DC1);
      6'd33: c = f_op(OP_ADD, D_T1, S_T1, S_W1, 1'b0, SH_F);
      6'd34: c = f_coef(f_op(OP_MUL, D_X, S_COEF, S_T1, 1'b0, SH_F), 1'b0, C_SRCT);
      6'd35: c = f_op(OP_DEAD, D_T1, S_MED, S_ZERO, 1'b0, SH_F);
      6'd36: c = f_mem(OP_STORE, D_NONE, S_T1, M_DC0);
      6'd37: c = f_op(OP_DEAD, D_T1, S_X, S_ZERO, 1'b0, SH_F);
      6'd38: c = f_jmp(f_mem(OP_STORE, D_NONE, S_T1, M_DC1), CND_ALWAYS, PC_BODY, 1'b1);
      6'd39: c = f_op(OP_MUL, D_Y, S_X, S_AMOUNT, 1'b0, SH_16);
      6'd40: c = f_jmp(f_op(OP_NOP, D_NONE, S_ZERO, S_ZERO, 1'b0, SH_F),
                       CND_LISTEN, PC_OUTSC, 1'b0);
      6'd41: c = f_op(OP_MUL, D_T1, S_SAMPLE, S_ONE, 1'b0, SH_23);
      6'd42: c = f_op(OP_ADD, D_Y, S_Y, S_T1, 1'b0, SH_F);
      6'd43: c = f_op(OP_MUL, D_Y, S_Y, S_LVOUT, 1'b0, SH_OUT);
      default: c = f_op(OP_END, D_NONE, S_ZERO, S_ZERO, 1'b0, SH_F);
    endcase
    return c;
  endfunction

endpackage

>>> hdl/harmonic_exciter_core.sv
// ============================================================================
// Harmonic exciter core
// Per-channel audio exciter run by a microcoded sequencer over a shared
// multiplier, a square-root unit, a saturating adder and a state memory.
// ============================================================================
// A word on the input channel is either an audio sample or a coefficient
// write. A coefficient write gives no result. An audio sample is worked off
// by a microprogram of 45 steps on the 24x24 multiplier, which builds each
// product from 24x24 partial products, and on the 40-step square root. One
// sample is processed at a time, and a new word is taken as soon as the
// previous result sits in the output register. After reset all 128 words of
// the filter memory are cleared, during which no input word is taken.
module harmonic_exciter_core
  import hexc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [22:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [2:0]         in_channel,
  input  logic signed [23:0] in_sample_in,
  input  logic               in_bypass,
  input  logic [4:0]         in_coef_index,
  input  logic signed [47:0] in_coef_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_channel_out,
  output logic signed [23:0] out_sample_out,
  output logic               out_clipped
);

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_EXEC, ST_WAIT, ST_DONE} state_t;

  localparam logic signed [49:0] SAT_HI = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] SAT_LO = 50'sh3_8000_0000_0000;
  localparam logic signed [49:0] DZ50   = $signed({2'b00, DEAD_ZONE});

  state_t          state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [2:0]      bq_r, bq_nxt;
  ctl_t            ctl;

  logic [22:0] level_in_r, level_out_r, amount_r;
  logic        listen_r, lp_en_r;

  logic signed [47:0] coef_r [NCOEF];
  logic signed [47:0] x_r, bo_r, t1_r, t2_r, med_r, y_r, w0_r, w1_r;
  logic signed [23:0] sample_r;
  logic               bypass_r;
  logic [2:0]         ch_r;

  logic [47:0]       mem_r [MEM_DEPTH];
  logic [47:0]       mem_q_r;
  logic [MEM_AW-1:0] mem_addr, clr_cnt_r;
  logic              mem_we;
  logic [47:0]       mem_wd;
  logic [3:0]        slot;

  logic [4:0]         coef_addr;
  logic signed [47:0] coef_q, opa, opb;
  logic signed [49:0] a50, b50, badj, sum50, abs50;
  logic signed [47:0] add_res, dead_res;

  logic               wb_en, advance, taken, mul_start, sq_start, out_load;
  logic signed [47:0] wb_val;

  logic               mul_busy_r, mul_neg_r;
  logic [2:0]         mul_cnt_r;
  logic [47:0]        mul_a_r, mul_b_r;
  sh_t                mul_sh_r;
  logic [95:0]        mul_acc_r, pp_sh, shv;
  logic [23:0]        xa, xb;
  logic [47:0]        pp, mul_mag;
  logic signed [47:0] mul_res_r;
  logic               mul_done;

  logic        sq_busy_r;
  logic [5:0]  sq_cnt_r;
  logic [79:0] sq_n_r;
  logic [39:0] sq_root_r;
  logic [41:0] sq_rem_r;
  logic [43:0] rem2, trial;
  logic [47:0] sq_v;
  logic        sq_done;

  logic               out_valid_r, out_clipped_r;
  logic [2:0]         out_channel_r;
  logic signed [23:0] out_sample_r, sat_sample;
  logic               sat_clip;

  logic in_acc, audio_acc, ch_ok;

  assign ctl       = ucode(pc_r);
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign ch_ok     = (32'(in_channel) < CHANNELS);
  assign audio_acc = in_acc && !in_kind && ch_ok;

  assign coef_addr = ctl.coef_rel ? (ctl.coef_idx + ((bq_r >= 3'd4) ? C_LP_BASE : 5'd0))
                                  : ctl.coef_idx;
  assign coef_q = coef_r[coef_addr];

  always_comb begin
    case (ctl.src_a)
      S_X:      opa = x_r;
      S_BO:     opa = bo_r;
      S_T1:     opa = t1_r;
      S_T2:     opa = t2_r;
      S_MED:    opa = med_r;
      S_Y:      opa = y_r;
      S_W0:     opa = w0_r;
      S_W1:     opa = w1_r;
      S_COEF:   opa = coef_q;
      S_SAMPLE: opa = 48'(sample_r);
      S_LVIN:   opa = {25'b0, level_in_r};
      S_LVOUT:  opa = {25'b0, level_out_r};
      S_AMOUNT: opa = {25'b0, amount_r};
      S_ONE:    opa = ONE_Q;
      default:  opa = '0;
    endcase
    case (ctl.src_b)
      S_X:      opb = x_r;
      S_BO:     opb = bo_r;
      S_T1:     opb = t1_r;
      S_T2:     opb = t2_r;
      S_MED:    opb = med_r;
      S_Y:      opb = y_r;
      S_W0:     opb = w0_r;
      S_W1:     opb = w1_r;
      S_COEF:   opb = coef_q;
      S_SAMPLE: opb = 48'(sample_r);
      S_LVIN:   opb = {25'b0, level_in_r};
      S_LVOUT:  opb = {25'b0, level_out_r};
      S_AMOUNT: opb = {25'b0, amount_r};
      S_ONE:    opb = ONE_Q;
      default:  opb = '0;
    endcase
  end

  always_comb begin
    a50   = 50'(opa);
    b50   = 50'(opb);
    badj  = ctl.neg_b ? -b50 : b50;
    sum50 = a50 + badj;
    if (sum50 > SAT_HI) begin
      add_res = MAX48;
    end else if (sum50 < SAT_LO) begin
      add_res = MIN48;
    end else begin
      add_res = sum50[47:0];
    end
    abs50    = (a50 < 0) ? -a50 : a50;
    dead_res = (abs50 > DZ50) ? opa : '0;
  end

  always_comb begin
    unique case (ctl.mem)
      M_BQ0: slot = {bq_r, 1'b0};
      M_BQ1: slot = {bq_r, 1'b1};
      M_DC0: slot = SLOT_DC0;
      M_DC1: slot = SLOT_DC1;
    endcase
    mem_addr = (state_r == ST_CLEAR) ? clr_cnt_r : MEM_AW'({ch_r, slot});
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_addr] <= mem_wd;
    end
    mem_q_r <= mem_r[mem_addr];
  end

  always_comb begin
    unique case (mul_cnt_r[1:0])
      2'd0: begin xa = mul_a_r[23:0];  xb = mul_b_r[23:0];  end
      2'd1: begin xa = mul_a_r[23:0];  xb = mul_b_r[47:24]; end
      2'd2: begin xa = mul_a_r[47:24]; xb = mul_b_r[23:0];  end
      2'd3: begin xa = mul_a_r[47:24]; xb = mul_b_r[47:24]; end
    endcase
    pp = xa * xb;
    unique case (mul_cnt_r[1:0])
      2'd0:    pp_sh = 96'(pp);
      2'd3:    pp_sh = 96'(pp) << 48;
      default: pp_sh = 96'(pp) << 24;
    endcase
    case (mul_sh_r)
      SH_IN:   shv = mul_acc_r >> (39 - COEF_FRACTION_BITS);
      SH_OUT:  shv = mul_acc_r >> (COEF_FRACTION_BITS - 7);
      SH_16:   shv = mul_acc_r >> 16;
      SH_23:   shv = mul_acc_r >> 23;
      default: shv = mul_acc_r >> COEF_FRACTION_BITS;
    endcase
    mul_mag  = (|shv[95:47]) ? MAX48 : shv[47:0];
    mul_done = mul_busy_r && (mul_cnt_r == 3'd5);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
    end else if (mul_start) begin
      mul_busy_r <= 1'b1;
      mul_cnt_r  <= 3'd0;
      mul_acc_r  <= '0;
      mul_a_r    <= opa[47] ? -opa : opa;
      mul_b_r    <= opb[47] ? -opb : opb;
      mul_neg_r  <= opa[47] ^ opb[47];
      mul_sh_r   <= ctl.sh;
    end else if (mul_busy_r) begin
      if (mul_cnt_r <= 3'd3) begin
        mul_acc_r <= mul_acc_r + pp_sh;
        mul_cnt_r <= mul_cnt_r + 3'd1;
      end else if (mul_cnt_r == 3'd4) begin
        mul_res_r <= mul_neg_r ? -mul_mag : mul_mag;
        mul_cnt_r <= 3'd5;
      end else begin
        mul_busy_r <= 1'b0;
      end
    end
  end

  assign sq_v    = opa[47] ? -opa : opa;
  assign rem2    = {sq_rem_r, sq_n_r[79:78]};
  assign trial   = {2'b00, sq_root_r, 2'b01};
  assign sq_done = sq_busy_r && (sq_cnt_r == 6'd40);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
    end else if (sq_start) begin
      sq_busy_r <= 1'b1;
      sq_root_r <= '0;
      sq_rem_r  <= '0;
      sq_n_r    <= 80'(sq_v) << COEF_FRACTION_BITS;
      sq_cnt_r  <= (sq_v <= DEAD_ZONE) ? 6'd40 : 6'd0;
    end else if (sq_busy_r) begin
      if (sq_cnt_r < 6'd40) begin
        if (rem2 >= trial) begin
          sq_rem_r  <= 42'(rem2 - trial);
          sq_root_r <= {sq_root_r[38:0], 1'b1};
        end else begin
          sq_rem_r  <= 42'(rem2);
          sq_root_r <= {sq_root_r[38:0], 1'b0};
        end
        sq_n_r   <= sq_n_r << 2;
        sq_cnt_r <= sq_cnt_r + 6'd1;
      end else begin
        sq_busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    unique case (ctl.cond)
      CND_NONE:     taken = 1'b0;
      CND_ALWAYS:   taken = 1'b1;
      CND_XNEG:     taken = x_r[47];
      CND_LOOP:     taken = (bq_r == 3'd0) || (bq_r == 3'd2) || (bq_r == 3'd4) ||
                            ((bq_r == 3'd3) && lp_en_r);
      CND_WET_DONE: taken = (bq_r != 3'd1);
      CND_LISTEN:   taken = listen_r;
      default:      taken = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    bq_nxt    = bq_r;
    wb_en     = 1'b0;
    wb_val    = add_res;
    mem_we    = 1'b0;
    mem_wd    = opa;
    mul_start = 1'b0;
    sq_start  = 1'b0;
    advance   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wd = '0;
        if (clr_cnt_r == MEM_AW'(MEM_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (audio_acc) begin
          state_nxt = ST_EXEC;
          pc_nxt    = '0;
          bq_nxt    = 3'd0;
        end
      end
      ST_EXEC: begin
        unique case (ctl.op)
          OP_NOP:   advance = 1'b1;
          OP_ADD: begin
            wb_en   = 1'b1;
            advance = 1'b1;
          end
          OP_DEAD: begin
            wb_en   = 1'b1;
            wb_val  = dead_res;
            advance = 1'b1;
          end
          OP_STORE: begin
            mem_we  = 1'b1;
            advance = 1'b1;
          end
          OP_LOAD:  state_nxt = ST_WAIT;
          OP_MUL: begin
            mul_start = 1'b1;
            state_nxt = ST_WAIT;
          end
          OP_SQRT: begin
            sq_start  = 1'b1;
            state_nxt = ST_WAIT;
          end
          OP_END:   state_nxt = ST_DONE;
        endcase
      end
      ST_WAIT: begin
        case (ctl.op)
          OP_LOAD: begin
            wb_en   = 1'b1;
            wb_val  = mem_q_r;
            advance = 1'b1;
          end
          OP_MUL: begin
            wb_en   = mul_done;
            wb_val  = mul_res_r;
            advance = mul_done;
          end
          OP_SQRT: begin
            wb_en   = sq_done;
            wb_val  = 48'(sq_root_r);
            advance = sq_done;
          end
          default: advance = 1'b1;
        endcase
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase
    if (advance) begin
      state_nxt = ST_EXEC;
      pc_nxt    = taken ? ctl.target : pc_r + 6'd1;
      if (taken && ctl.bq_inc) begin
        bq_nxt = bq_r + 3'd1;
      end
    end
  end

  always_comb begin
    sat_clip = 1'b0;
    if (y_r > 48'sd8388607) begin
      sat_sample = 24'sh7FFFFF;
      sat_clip   = 1'b1;
    end else if (y_r < -48'sd8388608) begin
      sat_sample = 24'sh800000;
      sat_clip   = 1'b1;
    end else begin
      sat_sample = y_r[23:0];
    end
    if (bypass_r) begin
      sat_sample = sample_r;
      sat_clip   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      pc_r        <= '0;
      bq_r        <= 3'd0;
      out_valid_r <= 1'b0;
      level_in_r  <= 23'd65536;
      level_out_r <= 23'd65536;
      amount_r    <= 23'd65536;
      listen_r    <= 1'b0;
      lp_en_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      bq_r    <= bq_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + MEM_AW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LEVEL_IN:  level_in_r  <= cfg_data;
          CFG_LEVEL_OUT: level_out_r <= cfg_data;
          CFG_AMOUNT:    amount_r    <= cfg_data;
          CFG_LISTEN:    listen_r    <= cfg_data[0];
          CFG_LOWPASS:   lp_en_r     <= cfg_data[0];
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_kind && (in_coef_index < 5'(NCOEF))) begin
      coef_r[in_coef_index] <= in_coef_value;
    end
    if (audio_acc) begin
      sample_r <= in_sample_in;
      bypass_r <= in_bypass;
      ch_r     <= in_channel;
    end
    if (out_load) begin
      out_channel_r <= ch_r;
      out_sample_r  <= sat_sample;
      out_clipped_r <= sat_clip;
    end
    if (wb_en) begin
      case (ctl.dst)
        D_X:     x_r   <= wb_val;
        D_BO:    bo_r  <= wb_val;
        D_T1:    t1_r  <= wb_val;
        D_T2:    t2_r  <= wb_val;
        D_MED:   med_r <= wb_val;
        D_Y:     y_r   <= wb_val;
        D_W0:    w0_r  <= wb_val;
        D_W1:    w1_r  <= wb_val;
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel_out = out_channel_r;
  assign out_sample_out  = out_sample_r;
  assign out_clipped     = out_clipped_r;

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_busy_r && sq_busy_r))
    else $error("multiplier and square root busy together");

  a_bq_range: assert property (@(posedge clk) disable iff (!rst_n)
    bq_r <= 3'd5)
    else $error("biquad stage counter out of range");

  a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT && ctl.op == OP_MUL) |-> mul_busy_r)
    else $error("waiting on an idle multiplier");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result word raised outside the done step");

  a_start_prog: assert property (@(posedge clk) disable iff (!rst_n)
    audio_acc |=> (state_r == ST_EXEC && pc_r == '0))
    else $error("accepted sample did not start the program");

endmodule
